FILE: sv/mdic_pkg.sv
// Shared types and constants for the mixed-radix index counter.
// Holds opcodes, register indexes, fixed field widths and the
// command/status structs between controller and datapath. No dependencies.
package mdic_pkg;

  localparam int NUM_OUT_DIMS  = 4;
  localparam int OUT_IDX_W     = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int RANK_W        = 3;
  localparam int OPCODE_W      = 2;
  localparam int PORT_ADDEND_W = 32;
  localparam int LIN_W         = 64;

  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_INC   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RANK       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_0 = 3'd1;

  typedef struct packed {
    logic load;
    logic exec;
    logic div_start;
    logic div_step;
    logic wb;
    logic wrap;
    logic out_load;
  } mdic_cmd_t;

  typedef struct packed {
    logic is_adv;
    logic carry_zero;
    logic digits_left;
    logic div_last;
  } mdic_status_t;

endpackage

FILE: sv/mdic_ctrl.sv
// Sequencing state machine of the mixed-radix index counter.
// Drives datapath commands and the input/result handshakes.
// Depends on mdic_pkg.
module mdic_ctrl
  import mdic_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  mdic_status_t status,
  output mdic_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DIV,
    S_WB,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.is_adv ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        if (status.carry_zero) begin
          state_nxt = S_OUT;
        end else if (!status.digits_left) begin
          // Carry left the outermost dimension.
          cmd.wrap  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = S_SCAN;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: sv/mdic_dpath.sv
// Datapath of the mixed-radix index counter: digit store, linear position,
// wrap flag, bit-serial restoring divider and the result register.
// Depends on mdic_pkg; commanded by mdic_ctrl.
module mdic_dpath
  import mdic_pkg::*;
#(
  parameter int MAX_RANK     = 4,
  parameter int DIM_WIDTH    = 16,
  parameter int ADDEND_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mdic_cmd_t                cmd,
  output mdic_status_t             status,
  input  logic [OPCODE_W-1:0]      in_opcode,
  input  logic [PORT_ADDEND_W-1:0] in_addend,
  input  logic [RANK_W-1:0]        rank_eff,
  input  logic [CFG_DATA_W-1:0]    dim_size [NUM_OUT_DIMS],
  output logic [OUT_IDX_W-1:0]     out_index [NUM_OUT_DIMS],
  output logic [LIN_W-1:0]         out_linear_index,
  output logic                     out_in_bounds
);

  // The carry can grow by one full digit per size-one dimension it passes.
  localparam int SUM_W  = ((ADDEND_WIDTH > DIM_WIDTH) ? ADDEND_WIDTH : DIM_WIDTH) + 3;
  localparam int DPTR_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int LIN_EXT_W = LIN_W + 1;

  logic [OPCODE_W-1:0]     op_r;
  logic [ADDEND_WIDTH-1:0] addend_r;
  logic [DIM_WIDTH-1:0]    digit_r [MAX_RANK];
  logic [LIN_W-1:0]        lin_r;
  logic                    wrapped_r;
  logic [SUM_W-1:0]        carry_r;
  logic [DPTR_W-1:0]       dptr_r;
  logic                    left_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [DIM_WIDTH-1:0]    divisor_r;
  logic [DIM_WIDTH-1:0]    rem_r;
  logic [SUM_W-1:0]        quo_r;
  logic [OUT_IDX_W-1:0]    out_index_r [NUM_OUT_DIMS];
  logic [LIN_W-1:0]        out_lin_r;
  logic                    out_in_bounds_r;

  logic [DIM_WIDTH-1:0]    size_eff [MAX_RANK];
  logic [63:0]             addend_wide;
  logic [ADDEND_WIDTH-1:0] amount;
  logic [LIN_EXT_W-1:0]    lin_sum;
  logic [LIN_W-1:0]        lin_nxt;
  logic [RANK_W-1:0]       rank_m1;
  logic [DIM_WIDTH-1:0]    cur_digit;
  logic [SUM_W-1:0]        div_sum;
  logic [DIM_WIDTH:0]      trial;
  logic [DIM_WIDTH:0]      diff;
  logic                    is_adv;

  // Size of each dimension as the digit arithmetic sees it: masked to the
  // digit width, with zero read as one.
  for (genvar k = 0; k < MAX_RANK; k++) begin : g_size
    logic [31:0]          raw_w;
    logic [DIM_WIDTH-1:0] masked;
    if (k < NUM_OUT_DIMS) begin : g_cfg
      assign raw_w = 32'(dim_size[k]);
    end else begin : g_fix
      assign raw_w = 32'd1;
    end
    assign masked      = raw_w[DIM_WIDTH-1:0];
    assign size_eff[k] = (masked == '0) ? DIM_WIDTH'(1) : masked;
  end

  assign is_adv      = (op_r == OP_INC) || (op_r == OP_ADD);
  assign addend_wide = 64'(in_addend);
  assign amount      = (op_r == OP_INC) ? ADDEND_WIDTH'(1) : addend_r;
  assign lin_sum     = {1'b0, lin_r} + LIN_EXT_W'(amount);
  assign lin_nxt     = lin_sum[LIN_W] ? '1 : lin_sum[LIN_W-1:0];
  assign rank_m1     = rank_eff - 3'd1;
  assign cur_digit   = digit_r[dptr_r];
  assign div_sum     = SUM_W'(cur_digit) + carry_r;
  assign trial       = {rem_r, quo_r[SUM_W-1]};
  assign diff        = trial - {1'b0, divisor_r};

  assign status.is_adv      = is_adv;
  assign status.carry_zero  = (carry_r == '0);
  assign status.digits_left = left_r;
  assign status.div_last    = (cnt_r == CNT_W'(SUM_W - 1));

  // Architectural state and loop control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_RANK; k++) begin
        digit_r[k] <= '0;
      end
      lin_r     <= '0;
      wrapped_r <= 1'b0;
      carry_r   <= '0;
      dptr_r    <= '0;
      left_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (cmd.exec) begin
        if (op_r == OP_CLEAR) begin
          for (int k = 0; k < MAX_RANK; k++) begin
            digit_r[k] <= '0;
          end
          lin_r     <= '0;
          wrapped_r <= 1'b0;
        end else if (is_adv) begin
          lin_r   <= lin_nxt;
          carry_r <= SUM_W'(amount);
          dptr_r  <= rank_m1[DPTR_W-1:0];
          left_r  <= 1'b1;
        end
      end
      if (cmd.wrap) begin
        wrapped_r <= 1'b1;
      end
      if (cmd.div_start) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.wb) begin
        digit_r[dptr_r] <= rem_r;
        carry_r         <= quo_r;
        if (dptr_r == '0) begin
          left_r <= 1'b0;
        end else begin
          dptr_r <= dptr_r - DPTR_W'(1);
        end
      end
    end
  end

  // Item latch and divider working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_opcode;
      addend_r <= addend_wide[ADDEND_WIDTH-1:0];
    end
    if (cmd.div_start) begin
      divisor_r <= size_eff[dptr_r];
      rem_r     <= '0;
      quo_r     <= div_sum;
    end else if (cmd.div_step) begin
      rem_r <= diff[DIM_WIDTH] ? trial[DIM_WIDTH-1:0] : diff[DIM_WIDTH-1:0];
      quo_r <= {quo_r[SUM_W-2:0], ~diff[DIM_WIDTH]};
    end
  end

  // Result register; inactive dimensions report zero.
  for (genvar k = 0; k < NUM_OUT_DIMS; k++) begin : g_out
    logic [OUT_IDX_W-1:0] val;
    if (k < MAX_RANK) begin : g_act
      logic [31:0] digit_w;
      assign digit_w = 32'(digit_r[k]);
      assign val = (RANK_W'(k) < rank_eff) ? digit_w[OUT_IDX_W-1:0] : '0;
    end else begin : g_off
      assign val = '0;
    end
    always_ff @(posedge clk) begin
      if (cmd.out_load) begin
        out_index_r[k] <= val;
      end
    end
    assign out_index[k] = out_index_r[k];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_lin_r       <= lin_r;
      out_in_bounds_r <= ~wrapped_r;
    end
  end

  assign out_linear_index = out_lin_r;
  assign out_in_bounds    = out_in_bounds_r;

`ifndef SYNTHESIS
  // A division runs exactly one step per quotient bit before write-back.
  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> ##(SUM_W + 1) cmd.wb)
    else $error("divider did not finish in the expected number of steps");

  // The remainder written back is always a legal digit for its dimension.
  a_rem_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |-> (rem_r < divisor_r))
    else $error("remainder not below divisor at write-back");
`endif

endmodule

FILE: sv/multi_dim_index_counter_top.sv
// Top level of the mixed-radix N-dimensional index counter.
// Holds the configuration registers and joins mdic_ctrl with mdic_dpath.
// Depends on mdic_pkg, mdic_ctrl and mdic_dpath.

// The block keeps an index of up to MAX_RANK dimensions as a mixed-radix
// number, the last active dimension innermost, plus a saturating 64-bit
// linear position and a sticky wrap flag reported as in_bounds. Each input
// transfer yields exactly one result transfer carrying the state after the
// update. A clear or the unused opcode goes from idle through an execute
// step to the output step, where the result is loaded into the result
// register. An increment or add goes from idle through execute and then,
// for each dimension the carry reaches (at most the active rank), through
// a scan, the division steps and a write-back, with a last scan before
// the output step. S = max(ADDEND_WIDTH, DIM_WIDTH) + 3 is the width of
// the shared restoring divider, which retires one quotient bit per cycle.
// With the default parameters S is 35.
// One item is in flight at a time; the result register lets the next input
// transfer start while the previous result still waits, and an item only
// stalls in its last cycle until that earlier result has transferred. The
// configuration port is always ready and must only be written while the
// block is idle.
module multi_dim_index_counter_top
  import mdic_pkg::*;
#(
  parameter int MAX_RANK     = 4,
  parameter int DIM_WIDTH    = 16,
  parameter int ADDEND_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input item channel.
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OPCODE_W-1:0]      in_opcode,
  input  logic [PORT_ADDEND_W-1:0] in_addend,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OUT_IDX_W-1:0]     out_index_0,
  output logic [OUT_IDX_W-1:0]     out_index_1,
  output logic [OUT_IDX_W-1:0]     out_index_2,
  output logic [OUT_IDX_W-1:0]     out_index_3,
  output logic [LIN_W-1:0]         out_linear_index,
  output logic                     out_in_bounds,
  // Configuration write channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  logic [RANK_W-1:0]     rank_r;
  logic [CFG_DATA_W-1:0] dim_size_r [NUM_OUT_DIMS];
  logic [RANK_W-1:0]     rank_eff;
  logic [OUT_IDX_W-1:0]  out_index [NUM_OUT_DIMS];
  logic                  cfg_write;
  mdic_cmd_t             cmd;
  mdic_status_t          status;

  // Configuration writes are accepted every cycle.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // The rank register keeps its three written bits; the counter clamps it
  // to one or MAX_RANK when it is out of range. Writes to indexes past the
  // last dimension size are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= RANK_W'(1);
      for (int k = 0; k < NUM_OUT_DIMS; k++) begin
        dim_size_r[k] <= CFG_DATA_W'(1);
      end
    end else if (cfg_write) begin
      if (cfg_index == CFG_RANK) begin
        rank_r <= cfg_wdata[RANK_W-1:0];
      end
      for (int k = 0; k < NUM_OUT_DIMS; k++) begin
        if (cfg_index == CFG_DIM_SIZE_0 + CFG_IDX_W'(k)) begin
          dim_size_r[k] <= cfg_wdata;
        end
      end
    end
  end

  always_comb begin
    if (rank_r == '0) begin
      rank_eff = RANK_W'(1);
    end else if (rank_r > RANK_W'(MAX_RANK)) begin
      rank_eff = RANK_W'(MAX_RANK);
    end else begin
      rank_eff = rank_r;
    end
  end

  mdic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mdic_dpath #(
    .MAX_RANK     (MAX_RANK),
    .DIM_WIDTH    (DIM_WIDTH),
    .ADDEND_WIDTH (ADDEND_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_opcode        (in_opcode),
    .in_addend        (in_addend),
    .rank_eff         (rank_eff),
    .dim_size         (dim_size_r),
    .out_index        (out_index),
    .out_linear_index (out_linear_index),
    .out_in_bounds    (out_in_bounds)
  );

  assign out_index_0 = out_index[0];
  assign out_index_1 = out_index[1];
  assign out_index_2 = out_index[2];
  assign out_index_3 = out_index[3];

`ifndef SYNTHESIS
  // Once an item is taken, the block is busy with it in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again while an item is in progress");

  // A new result only appears at the end of an item's processing.
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result presented without an item in progress");
`endif

endmodule
